### design/sipict_pkg.sv
`default_nettype none

package sipict_pkg;

    localparam int KIND_W     = 3;
    localparam int CODE_W     = 10;
    localparam int INTERVAL_W = 16;
    localparam int TIMER_A_W  = 17;
    localparam int STATE_W    = 3;

    localparam logic [INTERVAL_W-1:0] T1_RESET = 16'd500;

    // Status class boundaries
    localparam logic [CODE_W-1:0] CODE_1XX_LO   = 10'd100;
    localparam logic [CODE_W-1:0] CODE_2XX_LO   = 10'd200;
    localparam logic [CODE_W-1:0] CODE_3XX_LO   = 10'd300;
    localparam logic [CODE_W-1:0] CODE_FINAL_HI = 10'd700;

    typedef enum logic [KIND_W-1:0] {
        KIND_SENT_CONFIRM = 3'd0,
        KIND_USER_REQUEST = 3'd1,
        KIND_RESPONSE     = 3'd2,
        KIND_TIMER_A      = 3'd3,
        KIND_TIMER_B      = 3'd4,
        KIND_TIMER_D      = 3'd5,
        KIND_LIFESPAN     = 3'd6
    } kind_t;

    typedef enum logic [5:0] {
        ST_IDLE       = 6'b000001,
        ST_CALLING    = 6'b000010,
        ST_PROCEEDING = 6'b000100,
        ST_COMPLETED  = 6'b001000,
        ST_CONNECTED  = 6'b010000,
        ST_TERMINATED = 6'b100000
    } state_t;

    localparam logic [STATE_W-1:0] CODE_IDLE       = 3'd0;
    localparam logic [STATE_W-1:0] CODE_CALLING    = 3'd1;
    localparam logic [STATE_W-1:0] CODE_PROCEEDING = 3'd2;
    localparam logic [STATE_W-1:0] CODE_COMPLETED  = 3'd3;
    localparam logic [STATE_W-1:0] CODE_CONNECTED  = 3'd4;
    localparam logic [STATE_W-1:0] CODE_TERMINATED = 3'd5;

    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [CODE_W-1:0]     status_code;
        logic [INTERVAL_W-1:0] timer_interval;
    } event_t;

    typedef struct packed {
        logic [STATE_W-1:0]   state_now;
        logic                 pass_to_user;
        logic                 timeout_to_user;
        logic                 send_request;
        logic                 send_ack;
        logic                 start_timer_a;
        logic [TIMER_A_W-1:0] timer_a_value;
        logic                 start_timer_b;
        logic                 stop_timers;
        logic                 start_timer_d;
        logic                 terminate;
        logic                 logic_error;
    } action_t;

    function automatic logic [STATE_W-1:0] state_code(input state_t st);
        logic [STATE_W-1:0] code;
        unique case (st)
            ST_IDLE:       code = CODE_IDLE;
            ST_CALLING:    code = CODE_CALLING;
            ST_PROCEEDING: code = CODE_PROCEEDING;
            ST_COMPLETED:  code = CODE_COMPLETED;
            ST_CONNECTED:  code = CODE_CONNECTED;
            default:       code = CODE_TERMINATED;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

### design/sipict_event_stage.sv
`default_nettype none

module sipict_event_stage
    import sipict_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    output logic        in_stall,
    input  wire event_t in_event,
    input  wire logic   take,
    output logic        ev_valid,
    output event_t      ev
);

    logic   ev_valid_reg;
    logic   ev_valid_next;
    event_t ev_reg;
    logic   accept;

    // Full and not draining this cycle -> hold off the sender
    assign in_stall = ev_valid_reg && !take;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        priority if (accept)
        begin
            ev_valid_next = 1'b1;
        end
        else if (take)
        begin
            ev_valid_next = 1'b0;
        end
        else
        begin
            ev_valid_next = ev_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_valid_reg <= 1'b0;
        end
        else
        begin
            ev_valid_reg <= ev_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ev_reg <= in_event;
        end
    end

    assign ev_valid = ev_valid_reg;
    assign ev       = ev_reg;

endmodule

`default_nettype wire

### design/sipict_decide.sv
`default_nettype none

module sipict_decide
    import sipict_pkg::*;
(
    input  wire event_t                  ev,
    input  wire state_t                  state,
    input  wire logic                    request_sent,
    input  wire logic [INTERVAL_W-1:0]   t1_interval,
    output state_t                       state_next,
    output logic                         request_sent_next,
    output action_t                      act
);

    state_t st_cur;
    logic   is_1xx;
    logic   is_2xx;
    logic   is_final_err;

    always_comb
    begin
        is_1xx       = (ev.status_code >= CODE_1XX_LO) && (ev.status_code < CODE_2XX_LO);
        is_2xx       = (ev.status_code >= CODE_2XX_LO) && (ev.status_code < CODE_3XX_LO);
        is_final_err = (ev.status_code >= CODE_3XX_LO) && (ev.status_code < CODE_FINAL_HI);
    end

    always_comb
    begin
        // Illegal encodings fold to terminated
        unique case (state)
            ST_IDLE, ST_CALLING, ST_PROCEEDING,
            ST_COMPLETED, ST_CONNECTED: st_cur = state;
            default:                    st_cur = ST_TERMINATED;
        endcase

        act               = '0;
        state_next        = st_cur;
        request_sent_next = request_sent;

        unique case (ev.kind)
            KIND_SENT_CONFIRM:
            begin
                if (st_cur == ST_IDLE)
                begin
                    state_next        = ST_CALLING;
                    act.start_timer_a = 1'b1;
                    act.timer_a_value = {1'b0, t1_interval};
                    act.start_timer_b = 1'b1;
                end
            end
            KIND_USER_REQUEST:
            begin
                if (st_cur == ST_IDLE && !request_sent)
                begin
                    request_sent_next = 1'b1;
                    act.send_request  = 1'b1;
                end
            end
            KIND_RESPONSE:
            begin
                unique case (st_cur)
                    ST_IDLE:
                    begin
                        // 1xx in idle behaves as if already calling
                        if (is_1xx)
                        begin
                            state_next       = ST_PROCEEDING;
                            act.stop_timers  = 1'b1;
                            act.pass_to_user = 1'b1;
                        end
                    end
                    ST_CALLING, ST_PROCEEDING:
                    begin
                        act.stop_timers = 1'b1;
                        if (is_1xx)
                        begin
                            state_next       = ST_PROCEEDING;
                            act.pass_to_user = 1'b1;
                        end
                        else if (is_2xx)
                        begin
                            state_next        = ST_CONNECTED;
                            act.pass_to_user  = 1'b1;
                            act.start_timer_d = 1'b1;
                        end
                        else if (is_final_err)
                        begin
                            state_next        = ST_COMPLETED;
                            act.pass_to_user  = 1'b1;
                            act.send_ack      = 1'b1;
                            act.start_timer_d = 1'b1;
                        end
                    end
                    ST_COMPLETED:
                    begin
                        act.send_ack = 1'b1;
                    end
                    ST_CONNECTED:
                    begin
                        act.pass_to_user = is_2xx;
                    end
                    default:
                    begin
                    end
                endcase
            end
            KIND_TIMER_A:
            begin
                if (st_cur == ST_CALLING)
                begin
                    // 16-bit interval doubled always fits in 17 bits
                    act.send_request  = 1'b1;
                    act.start_timer_a = 1'b1;
                    act.timer_a_value = {ev.timer_interval, 1'b0};
                end
            end
            KIND_TIMER_B:
            begin
                if (st_cur == ST_CALLING)
                begin
                    state_next          = ST_TERMINATED;
                    act.stop_timers     = 1'b1;
                    act.timeout_to_user = 1'b1;
                    act.terminate       = 1'b1;
                end
            end
            KIND_TIMER_D:
            begin
                if (st_cur == ST_COMPLETED || st_cur == ST_CONNECTED)
                begin
                    state_next    = ST_TERMINATED;
                    act.terminate = 1'b1;
                end
                else
                begin
                    act.logic_error = 1'b1;
                end
            end
            KIND_LIFESPAN:
            begin
                state_next          = ST_TERMINATED;
                act.timeout_to_user = 1'b1;
                act.terminate       = 1'b1;
            end
            default:
            begin
            end
        endcase

        act.state_now = state_code(state_next);
    end

endmodule

`default_nettype wire

### design/sipict_result_stage.sv
`default_nettype none

module sipict_result_stage
    import sipict_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    ev_valid,
    input  wire action_t act,
    output logic         take,
    output logic         out_valid,
    input  wire logic    out_stall,
    output action_t      result
);

    logic    out_valid_reg;
    logic    out_valid_next;
    action_t result_reg;

    // Register can load when empty or when the current result leaves
    assign take = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = take ? ev_valid : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && ev_valid)
        begin
            result_reg <= act;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

`default_nettype wire

### design/sip_invite_client_transaction_fsm.sv
// INVITE client transaction controller: one event in, one action word out.
//
// Input channel (in_valid / in_stall): kind, status_code, timer_interval.
// A transfer happens on a rising edge with in_valid high and in_stall low.
// Output channel (out_valid / out_stall): state after the event plus the action
// flags and the timer A interval (zero when timer A is not started). The user
// writes T1 via cfg_wr_en / cfg_wr_data only while idle; the block does not check.
//
// An event is first held in the event register; its action word is loaded
// into the result register, from which it leaves on the output channel.
// Throughput: one event per cycle while out_stall is low. The event register
// feeds the transition logic, which updates the state registers and loads the
// result register in the same cycle; the state is therefore current for the
// next event. When out_stall holds the result register, an empty event
// register still takes one event, then in_stall rises until the result leaves.
// Reset (rst_n low, async): state idle, request-sent flag clear, T1 = 500,
// both stages empty.
`default_nettype none

module sip_invite_client_transaction_fsm
    import sipict_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  cfg_wr_en,
    input  wire logic [INTERVAL_W-1:0] cfg_wr_data,

    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [KIND_W-1:0]     kind,
    input  wire logic [CODE_W-1:0]     status_code,
    input  wire logic [INTERVAL_W-1:0] timer_interval,

    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [STATE_W-1:0]         state_now,
    output logic                       pass_to_user,
    output logic                       timeout_to_user,
    output logic                       send_request,
    output logic                       send_ack,
    output logic                       start_timer_a,
    output logic [TIMER_A_W-1:0]       timer_a_value,
    output logic                       start_timer_b,
    output logic                       stop_timers,
    output logic                       start_timer_d,
    output logic                       terminate,
    output logic                       logic_error
);

    event_t                  in_event;
    event_t                  ev;
    logic                    ev_valid;
    logic                    take;
    action_t                 act;
    action_t                 result;

    state_t                  fsm_state_reg;
    state_t                  fsm_state_next;
    logic                    request_sent_reg;
    logic                    request_sent_next;
    logic [INTERVAL_W-1:0]   t1_interval_reg;

    assign in_event.kind           = kind;
    assign in_event.status_code    = status_code;
    assign in_event.timer_interval = timer_interval;

    sipict_event_stage u_event_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_event (in_event),
        .take     (take),
        .ev_valid (ev_valid),
        .ev       (ev)
    );

    sipict_decide u_decide (
        .ev                (ev),
        .state             (fsm_state_reg),
        .request_sent      (request_sent_reg),
        .t1_interval       (t1_interval_reg),
        .state_next        (fsm_state_next),
        .request_sent_next (request_sent_next),
        .act               (act)
    );

    sipict_result_stage u_result_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .ev_valid  (ev_valid),
        .act       (act),
        .take      (take),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result)
    );

    // Transaction state moves only when an event crosses into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_state_reg    <= ST_IDLE;
            request_sent_reg <= 1'b0;
        end
        else if (take && ev_valid)
        begin
            fsm_state_reg    <= fsm_state_next;
            request_sent_reg <= request_sent_next;
        end
    end

    // T1 register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_interval_reg <= T1_RESET;
        end
        else if (cfg_wr_en)
        begin
            t1_interval_reg <= cfg_wr_data;
        end
    end

    assign state_now       = result.state_now;
    assign pass_to_user    = result.pass_to_user;
    assign timeout_to_user = result.timeout_to_user;
    assign send_request    = result.send_request;
    assign send_ack        = result.send_ack;
    assign start_timer_a   = result.start_timer_a;
    assign timer_a_value   = result.timer_a_value;
    assign start_timer_b   = result.start_timer_b;
    assign stop_timers     = result.stop_timers;
    assign start_timer_d   = result.start_timer_d;
    assign terminate       = result.terminate;
    assign logic_error     = result.logic_error;

endmodule

`default_nettype wire

### test/sipict_checker.sv
`timescale 1ns / 1ps

// Watches both channels, predicts one action word per event transfer and
// compares the action words that leave the block, in order.
module sipict_checker
    import sipict_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  cfg_wr_en,
    input  wire logic [INTERVAL_W-1:0] cfg_wr_data,

    input  wire logic                  in_valid,
    input  wire logic                  in_stall,
    input  wire logic [KIND_W-1:0]     kind,
    input  wire logic [CODE_W-1:0]     status_code,
    input  wire logic [INTERVAL_W-1:0] timer_interval,

    input  wire logic                  out_valid,
    input  wire logic                  out_stall,
    input  wire logic [STATE_W-1:0]    state_now,
    input  wire logic                  pass_to_user,
    input  wire logic                  timeout_to_user,
    input  wire logic                  send_request,
    input  wire logic                  send_ack,
    input  wire logic                  start_timer_a,
    input  wire logic [TIMER_A_W-1:0]  timer_a_value,
    input  wire logic                  start_timer_b,
    input  wire logic                  stop_timers,
    input  wire logic                  start_timer_d,
    input  wire logic                  terminate,
    input  wire logic                  logic_error,

    output int                         error_count,
    output int                         backlog
);

    action_t               expected_actions[$];
    logic [STATE_W-1:0]    txn_state;
    logic                  req_sent;
    logic [INTERVAL_W-1:0] t1_ms;
    int                    mismatches;

    assign error_count = mismatches;

    function automatic bit in_class(input logic [CODE_W-1:0] code,
                                    input logic [CODE_W-1:0] lo,
                                    input logic [CODE_W-1:0] hi);
        return (code >= lo) && (code < hi);
    endfunction

    // Final or provisional response while calling or proceeding.
    function automatic void take_response(input logic [CODE_W-1:0] code,
                                          inout action_t act);
        act.stop_timers = 1'b1;
        if (in_class(code, CODE_1XX_LO, CODE_2XX_LO))
        begin
            txn_state        = CODE_PROCEEDING;
            act.pass_to_user = 1'b1;
        end
        else if (in_class(code, CODE_2XX_LO, CODE_3XX_LO))
        begin
            txn_state         = CODE_CONNECTED;
            act.pass_to_user  = 1'b1;
            act.start_timer_d = 1'b1;
        end
        else if (in_class(code, CODE_3XX_LO, CODE_FINAL_HI))
        begin
            txn_state         = CODE_COMPLETED;
            act.pass_to_user  = 1'b1;
            act.send_ack      = 1'b1;
            act.start_timer_d = 1'b1;
        end
    endfunction

    function automatic action_t advance_txn(input event_t ev);
        action_t            act;
        logic [TIMER_A_W:0] doubled;
        act = '0;
        case (ev.kind)
            KIND_SENT_CONFIRM:
                if (txn_state == CODE_IDLE)
                begin
                    txn_state         = CODE_CALLING;
                    act.start_timer_a = 1'b1;
                    act.timer_a_value = {1'b0, t1_ms};
                    act.start_timer_b = 1'b1;
                end
            KIND_USER_REQUEST:
                if (txn_state == CODE_IDLE && !req_sent)
                begin
                    req_sent         = 1'b1;
                    act.send_request = 1'b1;
                end
            KIND_RESPONSE:
                case (txn_state)
                    CODE_IDLE:
                        if (in_class(ev.status_code, CODE_1XX_LO, CODE_2XX_LO))
                        begin
                            txn_state = CODE_CALLING;
                            take_response(ev.status_code, act);
                        end
                    CODE_CALLING, CODE_PROCEEDING:
                        take_response(ev.status_code, act);
                    CODE_COMPLETED:
                        act.send_ack = 1'b1;
                    CODE_CONNECTED:
                        if (in_class(ev.status_code, CODE_2XX_LO, CODE_3XX_LO))
                            act.pass_to_user = 1'b1;
                    default:
                        ;
                endcase
            KIND_TIMER_A:
                if (txn_state == CODE_CALLING)
                begin
                    doubled = {1'b0, ev.timer_interval, 1'b0};
                    if (doubled > {1'b0, {TIMER_A_W{1'b1}}})
                        act.timer_a_value = '1;
                    else
                        act.timer_a_value = doubled[TIMER_A_W-1:0];
                    act.send_request  = 1'b1;
                    act.start_timer_a = 1'b1;
                end
            KIND_TIMER_B:
                if (txn_state == CODE_CALLING)
                begin
                    txn_state           = CODE_TERMINATED;
                    act.stop_timers     = 1'b1;
                    act.timeout_to_user = 1'b1;
                    act.terminate       = 1'b1;
                end
            KIND_TIMER_D:
                if (txn_state == CODE_COMPLETED || txn_state == CODE_CONNECTED)
                begin
                    txn_state     = CODE_TERMINATED;
                    act.terminate = 1'b1;
                end
                else
                    act.logic_error = 1'b1;
            KIND_LIFESPAN:
            begin
                txn_state           = CODE_TERMINATED;
                act.timeout_to_user = 1'b1;
                act.terminate       = 1'b1;
            end
            default:
                ;
        endcase
        act.state_now = txn_state;
        return act;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned seen);
        if (want != seen)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, seen);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        event_t  ev;
        action_t want;
        if (!rst_n)
        begin
            txn_state  = CODE_IDLE;
            req_sent   = 1'b0;
            t1_ms      = T1_RESET;
            mismatches = 0;
            expected_actions.delete();
            backlog <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                t1_ms = cfg_wr_data;

            if (out_valid && !out_stall)
            begin
                if (expected_actions.size() == 0)
                begin
                    $display("%0t: action word expected none, got state %0d",
                             $time, state_now);
                    mismatches++;
                end
                else
                begin
                    want = expected_actions.pop_front();
                    check_field("state_now", want.state_now, state_now);
                    check_field("pass_to_user", want.pass_to_user, pass_to_user);
                    check_field("timeout_to_user", want.timeout_to_user,
                                timeout_to_user);
                    check_field("send_request", want.send_request, send_request);
                    check_field("send_ack", want.send_ack, send_ack);
                    check_field("start_timer_a", want.start_timer_a, start_timer_a);
                    check_field("timer_a_value", want.timer_a_value, timer_a_value);
                    check_field("start_timer_b", want.start_timer_b, start_timer_b);
                    check_field("stop_timers", want.stop_timers, stop_timers);
                    check_field("start_timer_d", want.start_timer_d, start_timer_d);
                    check_field("terminate", want.terminate, terminate);
                    check_field("logic_error", want.logic_error, logic_error);
                end
            end

            if (in_valid && !in_stall)
            begin
                ev.kind           = kind;
                ev.status_code    = status_code;
                ev.timer_interval = timer_interval;
                expected_actions.push_back(advance_txn(ev));
            end

            backlog <= expected_actions.size();
        end
    end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the INVITE client transaction block.
//
// The transaction only moves forward (idle -> calling -> proceeding ->
// completed/connected -> terminated) and reset is applied once, so the run
// is laid out as one long transaction: a short directed opening in idle and
// calling, then one random stretch per state. Each stretch sends mostly
// events that keep the block where it is, then one event that moves it on.
// The last stretch, after termination, is plain noise over every kind.
module tb_top;
    import sipict_pkg::*;

    typedef enum int
    {
        PLAN_CALLING,
        PLAN_PROCEEDING,
        PLAN_ANSWERED,
        PLAN_CLOSED
    } plan_t;

    // Kind code with no meaning; the block must ignore it.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

    localparam int ITEMS_PER_PLAN = 350;
    localparam int CYCLE_LIMIT    = 200000;

    logic                  clk;
    logic                  rst_n          = 1'b0;
    logic                  cfg_wr_en      = 1'b0;
    logic [INTERVAL_W-1:0] cfg_wr_data    = '0;
    logic                  in_valid       = 1'b0;
    logic                  in_stall;
    logic [KIND_W-1:0]     kind           = '0;
    logic [CODE_W-1:0]     status_code    = '0;
    logic [INTERVAL_W-1:0] timer_interval = '0;
    logic                  out_valid;
    logic                  out_stall      = 1'b0;
    logic [STATE_W-1:0]    state_now;
    logic                  pass_to_user;
    logic                  timeout_to_user;
    logic                  send_request;
    logic                  send_ack;
    logic                  start_timer_a;
    logic [TIMER_A_W-1:0]  timer_a_value;
    logic                  start_timer_b;
    logic                  stop_timers;
    logic                  start_timer_d;
    logic                  terminate;
    logic                  logic_error;

    int idle_pct    = 0;    // chance per cycle that the sender holds off
    int stall_pct   = 0;    // chance per cycle that the receiver stalls
    int cycle_count = 0;
    int error_count;
    int backlog;            // action words predicted but not yet seen

    sip_invite_client_transaction_fsm u_dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .kind            (kind),
        .status_code     (status_code),
        .timer_interval  (timer_interval),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .state_now       (state_now),
        .pass_to_user    (pass_to_user),
        .timeout_to_user (timeout_to_user),
        .send_request    (send_request),
        .send_ack        (send_ack),
        .start_timer_a   (start_timer_a),
        .timer_a_value   (timer_a_value),
        .start_timer_b   (start_timer_b),
        .stop_timers     (stop_timers),
        .start_timer_d   (start_timer_d),
        .terminate       (terminate),
        .logic_error     (logic_error)
    );

    sipict_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .kind            (kind),
        .status_code     (status_code),
        .timer_interval  (timer_interval),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .state_now       (state_now),
        .pass_to_user    (pass_to_user),
        .timeout_to_user (timeout_to_user),
        .send_request    (send_request),
        .send_ack        (send_ack),
        .start_timer_a   (start_timer_a),
        .timer_a_value   (timer_a_value),
        .start_timer_b   (start_timer_b),
        .stop_timers     (stop_timers),
        .start_timer_d   (start_timer_d),
        .terminate       (terminate),
        .logic_error     (logic_error),
        .error_count     (error_count),
        .backlog         (backlog)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver back-pressure, redrawn every cycle.
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // Hard stop in case the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic event_t mk_event(input logic [KIND_W-1:0] k,
                                        input int code, input int interval);
        event_t ev;
        ev.kind           = k;
        ev.status_code    = CODE_W'(code);
        ev.timer_interval = INTERVAL_W'(interval);
        return ev;
    endfunction

    // Status code that is neither provisional nor final: only stops timers
    // while calling or proceeding.
    function automatic int stray_code();
        if ($urandom_range(1) == 0)
            return $urandom_range(99);
        return $urandom_range(1023, 700);
    endfunction

    // Random event that leaves the transaction in the state the plan targets.
    // Code and interval are always random, so every bit toggles even where
    // the block ignores them.
    function automatic event_t pick_event(input plan_t plan);
        event_t ev;
        int     roll;
        ev   = mk_event(KIND_UNUSED, $urandom_range(1023), $urandom_range(65535));
        roll = $urandom_range(99);
        case (plan)
            PLAN_CALLING:
                if (roll < 35)
                    ev.kind = KIND_TIMER_A;
                else if (roll < 50)
                begin
                    ev.kind        = KIND_RESPONSE;
                    ev.status_code = CODE_W'(stray_code());
                end
                else if (roll < 62)
                    ev.kind = KIND_SENT_CONFIRM;
                else if (roll < 74)
                    ev.kind = KIND_USER_REQUEST;
                else if (roll < 87)
                    ev.kind = KIND_TIMER_D;
            PLAN_PROCEEDING:
                if (roll < 25)
                begin
                    ev.kind        = KIND_RESPONSE;
                    ev.status_code = CODE_W'($urandom_range(199, 100));
                end
                else if (roll < 40)
                begin
                    ev.kind        = KIND_RESPONSE;
                    ev.status_code = CODE_W'(stray_code());
                end
                else if (roll < 52)
                    ev.kind = KIND_TIMER_A;
                else if (roll < 64)
                    ev.kind = KIND_TIMER_B;
                else if (roll < 74)
                    ev.kind = KIND_SENT_CONFIRM;
                else if (roll < 84)
                    ev.kind = KIND_USER_REQUEST;
                else if (roll < 92)
                    ev.kind = KIND_TIMER_D;
            PLAN_ANSWERED:
                // completed or connected: anything but timer D and lifespan
                if (roll < 50)
                    ev.kind = KIND_RESPONSE;
                else if (roll < 60)
                    ev.kind = KIND_SENT_CONFIRM;
                else if (roll < 70)
                    ev.kind = KIND_USER_REQUEST;
                else if (roll < 80)
                    ev.kind = KIND_TIMER_A;
                else if (roll < 90)
                    ev.kind = KIND_TIMER_B;
            default:
                ev.kind = KIND_W'($urandom_range(7));
        endcase
        return ev;
    endfunction

    // One event transfer. Valid is only lowered here for a sender gap, so
    // back-to-back transfers keep it high.
    task automatic send_event(input event_t ev);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        kind           <= ev.kind;
        status_code    <= ev.status_code;
        timer_interval <= ev.timer_interval;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Hold off until every predicted action word has left the block.
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (backlog != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_t1(input logic [INTERVAL_W-1:0] ms);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= ms;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial
    begin
        event_t directed[$];
        plan_t  plan;
        int     roll;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // T1 only shows on the first timer A start, so pick it up front;
        // roll 0 keeps the reset value.
        roll = $urandom_range(3);
        if (roll == 1)
            write_t1(16'd1);
        else if (roll == 2)
            write_t1(16'hFFFF);
        else if (roll == 3)
            write_t1(INTERVAL_W'($urandom_range(65535, 1)));

        // Idle: request forwarded once, then ignored.
        directed.push_back(mk_event(KIND_USER_REQUEST, 0, 0));
        directed.push_back(mk_event(KIND_USER_REQUEST, 1023, 65535));
        // Idle: non-provisional responses ignored.
        directed.push_back(mk_event(KIND_RESPONSE, 0, 0));
        directed.push_back(mk_event(KIND_RESPONSE, 200, 1));
        directed.push_back(mk_event(KIND_RESPONSE, 1023, 65535));
        // Idle: timers A and B ignored, timer D is an error, unused kind.
        directed.push_back(mk_event(KIND_TIMER_A, 0, 500));
        directed.push_back(mk_event(KIND_TIMER_B, 0, 500));
        directed.push_back(mk_event(KIND_TIMER_D, 0, 500));
        directed.push_back(mk_event(KIND_UNUSED, 1023, 65535));
        // Leave idle: mostly by send confirm (T1 start), sometimes by a
        // provisional response taken as if already calling.
        if ($urandom_range(3) == 0)
            directed.push_back(mk_event(KIND_RESPONSE,
                                        ($urandom_range(1) != 0) ? 100 : 199, 0));
        else
            directed.push_back(mk_event(KIND_SENT_CONFIRM, 0, 0));
        // Calling: confirm and request ignored, timer A doubling at the
        // interval extremes, out-of-range codes only stop timers.
        directed.push_back(mk_event(KIND_SENT_CONFIRM, 512, 0));
        directed.push_back(mk_event(KIND_USER_REQUEST, 0, 0));
        directed.push_back(mk_event(KIND_TIMER_A, 0, 0));
        directed.push_back(mk_event(KIND_TIMER_A, 0, 65535));
        directed.push_back(mk_event(KIND_TIMER_A, 0, 1));
        directed.push_back(mk_event(KIND_RESPONSE, 99, 0));
        directed.push_back(mk_event(KIND_RESPONSE, 700, 0));
        directed.push_back(mk_event(KIND_TIMER_D, 0, 0));
        directed.push_back(mk_event(KIND_UNUSED, 0, 0));
        foreach (directed[i])
            send_event(directed[i]);
        drain();

        for (int p = 0; p < 4; p++)
        begin
            plan = plan_t'(p);
            case (plan)
                PLAN_CALLING:    begin idle_pct = 0;  stall_pct <= 0;  end
                PLAN_PROCEEDING: begin idle_pct = 61; stall_pct <= 0;  end
                PLAN_ANSWERED:   begin idle_pct = 0;  stall_pct <= 61; end
                default:         begin idle_pct = 25; stall_pct <= 25; end
            endcase

            repeat (ITEMS_PER_PLAN)
            begin
                send_event(pick_event(plan));
                // occasional full drain mid-stream
                if ($urandom_range(149) == 0)
                    drain();
            end

            // Move the transaction on, then retune T1 while it is quiet.
            case (plan)
                PLAN_CALLING:
                begin
                    if ($urandom_range(4) == 0)
                        send_event(mk_event(KIND_TIMER_B, 0, 0));
                    else
                        send_event(mk_event(KIND_RESPONSE,
                                            $urandom_range(199, 100), 0));
                    drain();
                    write_t1(16'hFFFF);
                end
                PLAN_PROCEEDING:
                begin
                    if ($urandom_range(1) == 0)
                        send_event(mk_event(KIND_RESPONSE,
                                            $urandom_range(299, 200), 0));
                    else
                        send_event(mk_event(KIND_RESPONSE,
                                            $urandom_range(699, 300), 0));
                    drain();
                    write_t1(16'd1);
                end
                PLAN_ANSWERED:
                begin
                    if ($urandom_range(1) == 0)
                        send_event(mk_event(KIND_TIMER_D, 0, 0));
                    else
                        send_event(mk_event(KIND_LIFESPAN, 0, 0));
                    drain();
                    write_t1(INTERVAL_W'($urandom_range(65535, 1)));
                end
                default:
                begin
                    drain();
                    write_t1(T1_RESET);
                end
            endcase
        end

        stall_pct <= 0;
        drain();
        repeat (4) @(posedge clk);

        if (error_count == 0 && backlog == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
